>>> design/ssoi_pkg.sv
// Shared types, constants and helper functions for the skid-steer odometry integrator.
// No dependencies; every other design file imports this package.

package ssoi_pkg;

    // Configuration register indexes.
    localparam logic REG_WHEEL_RADIUS = 1'b0;
    localparam logic REG_AXLE_LENGTH  = 1'b1;

    // Reset values of the configuration registers (1.0 in Q4.12).
    localparam logic [15:0] RADIUS_RESET = 16'd4096;
    localparam logic [15:0] AXLE_RESET   = 16'd4096;

    // Fixed widths of the datapath.
    localparam int MUL_A_W   = 64;
    localparam int MUL_B_W   = 32;
    localparam int MUL_CNT_W = 6;
    localparam int DIV_N_W   = 52;
    localparam int DIV_D_W   = 22;
    localparam int ATAN_COUNT = 30;

    // Operand bit counts for each serial multiply.
    localparam logic [MUL_CNT_W-1:0] BITS_RADIUS = 6'd16;
    localparam logic [MUL_CNT_W-1:0] BITS_GAIN   = 6'd30;
    localparam logic [MUL_CNT_W-1:0] BITS_DT     = 6'd20;
    localparam logic [MUL_CNT_W-1:0] BITS_TURN   = 6'd26;

    // CORDIC start gain in Q30 and the turn scale 2^48/(2*pi*10^6).
    localparam logic [29:0] GAIN_Q30   = 30'd652032875;
    localparam logic [25:0] TURN_SCALE = 26'd44798134;

    // Microseconds per second, and twice that for the rounding divide.
    localparam logic [DIV_D_W-1:0] US_PER_S   = 22'd1000000;
    localparam logic [DIV_D_W-1:0] US_PER_S_2 = 22'd2000000;

    // Arctangent of 2^-i as a binary angle (full turn = 2^32).
    function automatic logic [29:0] atan_ba(input logic [4:0] idx);
        logic [29:0] res;
        case (idx)
            5'd0:  res = 30'd536870912;
            5'd1:  res = 30'd316933406;
            5'd2:  res = 30'd167458907;
            5'd3:  res = 30'd85004756;
            5'd4:  res = 30'd42667331;
            5'd5:  res = 30'd21354465;
            5'd6:  res = 30'd10680350;
            5'd7:  res = 30'd5340245;
            5'd8:  res = 30'd2670163;
            5'd9:  res = 30'd1335087;
            5'd10: res = 30'd667544;
            5'd11: res = 30'd333772;
            5'd12: res = 30'd166886;
            5'd13: res = 30'd83443;
            5'd14: res = 30'd41722;
            5'd15: res = 30'd20861;
            5'd16: res = 30'd10430;
            5'd17: res = 30'd5215;
            5'd18: res = 30'd2608;
            5'd19: res = 30'd1304;
            5'd20: res = 30'd652;
            5'd21: res = 30'd326;
            5'd22: res = 30'd163;
            5'd23: res = 30'd81;
            5'd24: res = 30'd41;
            5'd25: res = 30'd20;
            5'd26: res = 30'd10;
            5'd27: res = 30'd5;
            5'd28: res = 30'd3;
            5'd29: res = 30'd1;
            default: res = 30'd0;
        endcase
        return res;
    endfunction

    // Saturate a 64-bit signed value to the 32-bit signed range.
    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > 64'sd2147483647) begin
            res = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

>>> design/ssoi_mul.sv
// Serial shift-and-add multiplier: one multiplier bit per cycle, product modulo 2^64.
// Depends on ssoi_pkg for widths.

module ssoi_mul (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic signed [ssoi_pkg::MUL_A_W-1:0]    i_a,
    input  logic [ssoi_pkg::MUL_B_W-1:0]           i_b,
    input  logic [ssoi_pkg::MUL_CNT_W-1:0]         i_nbits,
    output logic                                   o_done,
    output logic signed [ssoi_pkg::MUL_A_W-1:0]    o_p
);
    import ssoi_pkg::*;

    logic signed [MUL_A_W-1:0] r_a;
    logic [MUL_B_W-1:0]        r_b;
    logic signed [MUL_A_W-1:0] r_acc;
    logic [MUL_CNT_W-1:0]      r_cnt;
    logic                      r_busy;
    logic                      r_done;

    // Multiplicand shifts left while the multiplier bits leave at the bottom.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
                r_cnt  <= i_nbits;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_b[0]) begin
                    r_acc <= r_acc + r_a;
                end
                r_a   <= r_a <<< 1;
                r_b   <= r_b >> 1;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;

endmodule

>>> design/ssoi_div.sv
// Serial restoring divider: one quotient bit per cycle, unsigned operands.
// Depends on ssoi_pkg for widths.

module ssoi_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [ssoi_pkg::DIV_N_W-1:0]    i_n,
    input  logic [ssoi_pkg::DIV_D_W-1:0]    i_d,
    output logic                            o_done,
    output logic [ssoi_pkg::DIV_N_W-1:0]    o_q
);
    import ssoi_pkg::*;

    logic [DIV_N_W-1:0]   r_n;
    logic [DIV_D_W-1:0]   r_d;
    logic [DIV_D_W-1:0]   r_rem;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_D_W:0]     trial;
    logic [DIV_D_W:0]     diff;
    logic                 fits;

    // Bring down the next dividend bit and try a subtract.
    always_comb begin
        trial = {r_rem, r_n[DIV_N_W-1]};
        diff  = trial - {1'b0, r_d};
        fits  = trial >= {1'b0, r_d};
    end

    // Quotient bits shift into the dividend register from the bottom.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_n    <= i_n;
                r_d    <= i_d;
                r_rem  <= '0;
                r_cnt  <= MUL_CNT_W'(DIV_N_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
                r_n   <= {r_n[DIV_N_W-2:0], fits};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_n;

endmodule

>>> design/ssoi_cordic.sv
// Iterative rotation-mode CORDIC: one micro-rotation per cycle.
// Depends on ssoi_pkg for the arctangent table.

module ssoi_cordic #(
    parameter int STAGES = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [ssoi_pkg::MUL_A_W-1:0] i_x,
    input  logic signed [31:0]                  i_z,
    output logic                                o_done,
    output logic signed [ssoi_pkg::MUL_A_W-1:0] o_x,
    output logic signed [ssoi_pkg::MUL_A_W-1:0] o_y
);
    import ssoi_pkg::*;

    localparam int N_ROT = (STAGES < ATAN_COUNT) ? STAGES : ATAN_COUNT;

    logic signed [MUL_A_W-1:0] r_x;
    logic signed [MUL_A_W-1:0] r_y;
    logic signed [32:0]        r_z;
    logic [4:0]                r_i;
    logic                      r_busy;
    logic                      r_done;
    logic signed [MUL_A_W-1:0] dx;
    logic signed [MUL_A_W-1:0] dy;
    logic signed [32:0]        da;

    // Shifted cross terms and the angle of this step.
    always_comb begin
        dx = r_y >>> r_i;
        dy = r_x >>> r_i;
        da = $signed({3'b000, atan_ba(r_i)});
    end

    // Rotate toward a zero residual angle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x    <= i_x;
                r_y    <= '0;
                r_z    <= 33'(i_z);
                r_i    <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!r_z[32]) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - da;
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + da;
                end
                r_i <= r_i + 1'b1;
                if (r_i == 5'(N_ROT - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;

endmodule

>>> design/skid_steer_odometry_integrator.sv
// Skid-steer odometry integrator: a sequencer over a serial multiplier, a serial
// divider and an iterative CORDIC. Depends on ssoi_pkg, ssoi_mul, ssoi_div, ssoi_cordic.
//
// One beat of four wheel speeds and an elapsed time produces one beat of pose and
// velocity. Items are worked one at a time: seven serial multiplies (16+16+30+20+20
// +20+26 multiplier bits, one bit per cycle), three serial divides of 52 quotient bits
// and CORDIC_STAGES rotations, with a hand-off through the sequencer around each of
// those eleven unit runs, then a load of the output register once it is free. The
// next input beat is taken once the output register is loaded. The serial multiplier
// and divider set most of the time an item takes. A new input beat is taken while the
// previous result still waits on the output side.

module skid_steer_odometry_integrator #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration write port.
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [15:0]  i_cfg_data,
    // Input stream.
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // front_left_speed, back_left_speed, front_right_speed, back_right_speed,
    // elapsed_us, then four zero bits.
    input  logic [87:0]  i_s_axis_tdata,
    // Output stream.
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // pos_x, pos_y, heading_angle, vel_x, vel_y, yaw_rate.
    output logic [191:0] o_m_axis_tdata,
    // zero_interval.
    output logic         o_m_axis_tuser
);
    import ssoi_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL_V, S_MUL_D, S_DIV_W, S_MUL_G, S_CORDIC, S_MUL_X, S_DIV_X,
        S_MUL_Y, S_DIV_Y, S_MUL_WDT, S_MUL_TURN, S_OUT
    } t_state;

    t_state r_state;

    // Configuration and pose.
    logic [15:0]        r_radius;
    logic [15:0]        r_axle;
    logic signed [31:0] r_px;
    logic signed [31:0] r_py;
    logic [31:0]        r_head;

    // Per-item working registers.
    logic signed [17:0] r_dif;
    logic [19:0]        r_dt;
    logic signed [63:0] r_v;
    logic signed [31:0] r_w;
    logic signed [31:0] r_vx;
    logic signed [31:0] r_vy;
    logic [31:0]        r_angle;
    logic               r_fold;
    logic               r_neg;

    // Unit launches and operands.
    logic                 r_mul_start;
    logic signed [63:0]   r_mul_a;
    logic [31:0]          r_mul_b;
    logic [MUL_CNT_W-1:0] r_mul_n;
    logic                 r_div_start;
    logic [DIV_N_W-1:0]   r_div_n;
    logic [DIV_D_W-1:0]   r_div_d;
    logic                 r_cor_start;
    logic signed [63:0]   r_cor_x;

    // Output register.
    logic               r_out_valid;
    logic [191:0]       r_out_data;
    logic               r_out_zero;

    logic               mul_done;
    logic signed [63:0] mul_p;
    logic               div_done;
    logic [DIV_N_W-1:0] div_q;
    logic               cor_done;
    logic signed [63:0] cor_x;
    logic signed [63:0] cor_y;

    logic signed [15:0] in_fl;
    logic signed [15:0] in_bl;
    logic signed [15:0] in_fr;
    logic signed [15:0] in_br;
    logic signed [16:0] in_sl;
    logic signed [16:0] in_sr;
    logic signed [63:0] num_w;
    logic               p_neg;
    logic [63:0]        p_mag;
    logic [63:0]        w_mag;
    logic signed [63:0] q_signed;
    logic [31:0]        ang_test;
    logic signed [63:0] vx_full;
    logic signed [63:0] vy_full;
    logic [63:0]        turn;
    logic               in_accept;
    logic               out_free;

    ssoi_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_a     (r_mul_a),
        .i_b     (r_mul_b),
        .i_nbits (r_mul_n),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    ssoi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_n     (r_div_n),
        .i_d     (r_div_d),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    ssoi_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cor_start),
        .i_x     (r_cor_x),
        .i_z     ($signed(r_angle)),
        .o_done  (cor_done),
        .o_x     (cor_x),
        .o_y     (cor_y)
    );

    // Side sums of the incoming beat and the arithmetic around the units.
    always_comb begin
        in_fl    = i_s_axis_tdata[15:0];
        in_bl    = i_s_axis_tdata[31:16];
        in_fr    = i_s_axis_tdata[47:32];
        in_br    = i_s_axis_tdata[63:48];
        in_sl    = 17'(in_fl) + 17'(in_bl);
        in_sr    = 17'(in_fr) + 17'(in_br);
        num_w    = mul_p <<< 7;
        p_neg    = mul_p[63];
        p_mag    = p_neg ? 64'(-mul_p) : 64'(mul_p);
        w_mag    = num_w[63] ? 64'(-num_w) : 64'(num_w);
        q_signed = r_neg ? -$signed({12'b0, div_q}) : $signed({12'b0, div_q});
        ang_test = r_head + 32'h40000000;
        vx_full  = (cor_x + 64'sd536870912) >>> 30;
        vy_full  = (cor_y + 64'sd536870912) >>> 30;
        turn     = 64'(mul_p) + 64'h80000000;
        in_accept = i_s_axis_tvalid && o_s_axis_tready;
        out_free  = !r_out_valid || i_m_axis_tready;
    end

    // Configuration registers; a zero write is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
            r_axle   <= AXLE_RESET;
        end else if (i_cfg_we && (i_cfg_data != 16'd0)) begin
            case (i_cfg_index)
                REG_WHEEL_RADIUS: r_radius <= i_cfg_data;
                REG_AXLE_LENGTH:  r_axle   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer: state, pose, launches and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_px        <= '0;
            r_py        <= '0;
            r_head      <= '0;
            r_mul_start <= 1'b0;
            r_div_start <= 1'b0;
            r_cor_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mul_start <= 1'b0;
            r_div_start <= 1'b0;
            r_cor_start <= 1'b0;
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_dif       <= 18'(in_sr) - 18'(in_sl);
                        r_dt        <= i_s_axis_tdata[83:64];
                        r_mul_a     <= 64'(18'(in_sl) + 18'(in_sr));
                        r_mul_b     <= 32'(r_radius);
                        r_mul_n     <= BITS_RADIUS;
                        r_mul_start <= 1'b1;
                        r_state     <= S_MUL_V;
                    end
                end
                S_MUL_V: begin
                    if (mul_done) begin
                        r_v         <= (mul_p + 64'sd32) >>> 6;
                        r_mul_a     <= 64'(r_dif);
                        r_mul_b     <= 32'(r_radius);
                        r_mul_n     <= BITS_RADIUS;
                        r_mul_start <= 1'b1;
                        r_state     <= S_MUL_D;
                    end
                end
                S_MUL_D: begin
                    if (mul_done) begin
                        r_neg       <= num_w[63];
                        r_div_n     <= DIV_N_W'((w_mag << 1) + 64'(r_axle));
                        r_div_d     <= DIV_D_W'({r_axle, 1'b0});
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV_W;
                    end
                end
                S_DIV_W: begin
                    if (div_done) begin
                        r_w         <= clamp32(q_signed);
                        r_fold      <= ang_test[31];
                        r_angle     <= ang_test[31] ? r_head + 32'h80000000 : r_head;
                        r_mul_a     <= r_v;
                        r_mul_b     <= 32'(GAIN_Q30);
                        r_mul_n     <= BITS_GAIN;
                        r_mul_start <= 1'b1;
                        r_state     <= S_MUL_G;
                    end
                end
                S_MUL_G: begin
                    if (mul_done) begin
                        r_cor_x     <= r_fold ? -mul_p : mul_p;
                        r_cor_start <= 1'b1;
                        r_state     <= S_CORDIC;
                    end
                end
                S_CORDIC: begin
                    if (cor_done) begin
                        r_vx        <= clamp32(vx_full);
                        r_vy        <= clamp32(vy_full);
                        r_mul_a     <= vx_full;
                        r_mul_b     <= 32'(r_dt);
                        r_mul_n     <= BITS_DT;
                        r_mul_start <= 1'b1;
                        r_state     <= S_MUL_X;
                    end
                end
                S_MUL_X, S_MUL_Y: begin
                    if (mul_done) begin
                        r_neg       <= p_neg;
                        r_div_n     <= DIV_N_W'((p_mag << 1) + 64'(US_PER_S));
                        r_div_d     <= US_PER_S_2;
                        r_div_start <= 1'b1;
                        r_state     <= (r_state == S_MUL_X) ? S_DIV_X : S_DIV_Y;
                    end
                end
                S_DIV_X: begin
                    if (div_done) begin
                        r_px        <= clamp32(64'(r_px) + q_signed);
                        r_mul_a     <= 64'(r_vy);
                        r_mul_b     <= 32'(r_dt);
                        r_mul_n     <= BITS_DT;
                        r_mul_start <= 1'b1;
                        r_state     <= S_MUL_Y;
                    end
                end
                S_DIV_Y: begin
                    if (div_done) begin
                        r_py        <= clamp32(64'(r_py) + q_signed);
                        r_mul_a     <= 64'(r_w);
                        r_mul_b     <= 32'(r_dt);
                        r_mul_n     <= BITS_DT;
                        r_mul_start <= 1'b1;
                        r_state     <= S_MUL_WDT;
                    end
                end
                S_MUL_WDT: begin
                    if (mul_done) begin
                        r_mul_a     <= mul_p;
                        r_mul_b     <= 32'(TURN_SCALE);
                        r_mul_n     <= BITS_TURN;
                        r_mul_start <= 1'b1;
                        r_state     <= S_MUL_TURN;
                    end
                end
                S_MUL_TURN: begin
                    if (mul_done) begin
                        r_head  <= r_head + turn[63:32];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_data  <= {r_w, r_vy, r_vx, r_head, r_py, r_px};
                        r_out_zero  <= (r_dt == 20'd0);
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_zero;

endmodule
